[rtl/core/u8s_pkg.sv]
// Package for the UTF-8 stream sanitizer: byte constants, the result word
// type and the lead-byte length decoder. Depends on nothing.
package u8s_pkg;

	localparam logic [7:0] QMARK      = 8'h3F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	// Sequence lengths implied by a byte; LEN_BAD marks a byte that cannot lead.
	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	// Depth of the result buffer in front of the output channel.
	localparam int unsigned PEND_DEPTH = 4;
	localparam int unsigned HELD_DEPTH = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       text_clean;
	} out_word_t;

	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] len;
		if (c[7] == 1'b0) begin
			len = LEN_1;
		end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
			len = LEN_2;
		end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
			len = LEN_3;
		end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
			len = LEN_4;
		end else begin
			len = LEN_BAD;
		end
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & CONT_MASK) == CONT_CODE;
	endfunction

endpackage

[rtl/core/u8s_if.sv]
// Valid/ready channel interfaces of the UTF-8 stream sanitizer: the raw byte
// input and the sanitized byte output. Depends on nothing.
interface u8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       text_clean;

	modport source (output valid, output out_byte, output out_last, output text_clean,
		input ready);
	modport sink   (input valid, input out_byte, input out_last, input text_clean,
		output ready);
endinterface

[rtl/core/utf8_stream_sanitizer.sv]
// Top level of the UTF-8 stream sanitizer: input register, sanitizing logic
// and result buffer. Depends on u8s_pkg and the interfaces in u8s_if.
//
// Usage. Raw text arrives on in_ch one word (a byte) per handshake, with
// in_last high on the final byte of a string. Sanitized bytes leave on out_ch;
// out_last marks the final byte of the string and text_clean, valid with it,
// is high when no byte of that string was replaced by a question mark.
// The single register, emoji_enable, is written through cfg_wr_en/cfg_wr_data
// and should only be changed while the block is idle.
// A word accepted on in_ch goes into the input register and is decoded there; its
// results are written into the result buffer, whose slot 0 is offered on out_ch.
// Throughput: one input word per cycle is sustained while the buffer has room. A word
// may yield up to four results; they wait in a four-entry result buffer that drains
// one word per cycle while out_ch is ready, and the input register holds its word only
// while the buffer (counting the word leaving in the same cycle) lacks room for them.
// When the receiver stalls the buffer fills and in_ch.ready falls after one
// more word has been taken into the input register.
// Reset clears the pending sequence, the string status and the buffer, and
// sets emoji_enable to one.
module utf8_stream_sanitizer
	import u8s_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	u8s_in_if.sink       in_ch,
	u8s_out_if.source    out_ch
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Sequence state: the lead byte and continuations held so far.
	logic [7:0] held_q [HELD_DEPTH];
	logic [1:0] held_cnt_q;
	logic       seen_bad_q;
	logic       emoji_q;

	// Result buffer, slot 0 faces the output channel.
	out_word_t  pend_q [PEND_DEPTH];
	logic [2:0] pend_cnt_q;

	// Decode of the word in the input register.
	logic [7:0] res_byte [PEND_DEPTH];
	out_word_t  res_word [PEND_DEPTH];
	logic [2:0] res_n;
	logic       res_bad;
	logic [1:0] held_cnt_nx;
	logic       store_en;
	logic [1:0] store_idx;

	logic [2:0] need;
	logic       cont;
	logic [2:0] fresh_len;
	logic       fresh_emit;
	logic       fresh_hold;
	logic       fresh_bad;
	logic [7:0] fresh_byte;
	logic       seen_bad_nx;

	logic       pop;
	logic       fire;
	logic [2:0] base;
	logic [3:0] fill;
	out_word_t  shifted [PEND_DEPTH];
	out_word_t  pend_nx [PEND_DEPTH];
	logic [2:0] slot_idx [PEND_DEPTH];
	logic [2:0] rel_idx [PEND_DEPTH];

	assign out_ch.valid      = (pend_cnt_q != 3'd0);
	assign out_ch.out_byte   = pend_q[0].out_byte;
	assign out_ch.out_last   = pend_q[0].out_last;
	assign out_ch.text_clean = pend_q[0].text_clean;

	assign pop = out_ch.valid && out_ch.ready;

	// What the input register's word would do on its own, were no bytes held:
	// ASCII passes, a bad lead or a lead that ends the string is replaced,
	// any other lead is held.
	assign fresh_len  = seq_len(byte_s1);
	assign fresh_emit = (fresh_len == LEN_1) || (fresh_len == LEN_BAD) || last_s1;
	assign fresh_bad  = (fresh_len != LEN_1) && ((fresh_len == LEN_BAD) || last_s1);
	assign fresh_hold = !fresh_emit;
	assign fresh_byte = (fresh_len == LEN_1) ? byte_s1 : QMARK;

	assign need = seq_len(held_q[0]);
	assign cont = is_cont(byte_s1);

	always_comb begin
		for (int i = 0; i < PEND_DEPTH; i++) begin
			res_byte[i] = QMARK;
		end
		res_n       = 3'd0;
		res_bad     = 1'b0;
		held_cnt_nx = held_cnt_q;
		store_en    = 1'b0;
		store_idx   = held_cnt_q;

		if (held_cnt_q != 2'd0 && cont && ({1'b0, held_cnt_q} + 3'd1 == need)) begin
			// The sequence completes with this byte.
			if (need == LEN_4 && !emoji_q) begin
				res_n   = 3'd1;
				res_bad = 1'b1;
			end else begin
				for (int i = 0; i < HELD_DEPTH; i++) begin
					res_byte[i] = (2'(i) < held_cnt_q) ? held_q[i] : byte_s1;
				end
				res_byte[PEND_DEPTH-1] = byte_s1;
				res_n = {1'b0, held_cnt_q} + 3'd1;
			end
			held_cnt_nx = 2'd0;
		end else if (held_cnt_q != 2'd0 && cont && !last_s1
				&& ({1'b0, held_cnt_q} + 3'd1 < need)) begin
			// Another continuation byte of an unfinished sequence.
			store_en    = 1'b1;
			held_cnt_nx = held_cnt_q + 2'd1;
		end else begin
			// Broken or cut-off sequence (or nothing held): every held byte turns
			// into a question mark and the new byte is looked at afresh.
			for (int i = 0; i < PEND_DEPTH; i++) begin
				res_byte[i] = (3'(i) < {1'b0, held_cnt_q}) ? QMARK : fresh_byte;
			end
			res_n       = {1'b0, held_cnt_q} + {2'b00, fresh_emit};
			res_bad     = (held_cnt_q != 2'd0) || fresh_bad;
			store_en    = fresh_hold;
			store_idx   = 2'd0;
			held_cnt_nx = fresh_hold ? 2'd1 : 2'd0;
		end
	end

	assign seen_bad_nx = seen_bad_q || res_bad;

	// The last result of a string carries the end mark and the clean flag.
	always_comb begin
		for (int i = 0; i < PEND_DEPTH; i++) begin
			res_word[i].out_byte   = res_byte[i];
			res_word[i].out_last   = last_s1 && (3'(i) == res_n - 3'd1);
			res_word[i].text_clean = last_s1 && (3'(i) == res_n - 3'd1) && !seen_bad_nx;
		end
	end

	// The word in the input register is decoded once its results fit.
	assign base = pend_cnt_q - {2'b00, pop};
	assign fill = {1'b0, base} + {1'b0, res_n};
	assign fire = valid_s1 && (fill <= 4'(PEND_DEPTH));

	assign in_ch.ready = !valid_s1 || fire;

	always_comb begin
		for (int j = 0; j < PEND_DEPTH; j++) begin
			shifted[j] = (pop && j < PEND_DEPTH - 1) ? pend_q[(j + 1) % PEND_DEPTH] : pend_q[j];
			slot_idx[j] = 3'(j);
			rel_idx[j]  = slot_idx[j] - base;
			if (fire && slot_idx[j] >= base && rel_idx[j] < res_n) begin
				pend_nx[j] = res_word[rel_idx[j][1:0]];
			end else begin
				pend_nx[j] = shifted[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			held_cnt_q <= 2'd0;
			seen_bad_q <= 1'b0;
			pend_cnt_q <= 3'd0;
			emoji_q    <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				emoji_q <= cfg_wr_data;
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (fire) begin
				held_cnt_q <= last_s1 ? 2'd0 : held_cnt_nx;
				seen_bad_q <= last_s1 ? 1'b0 : seen_bad_nx;
				pend_cnt_q <= fill[2:0];
			end else begin
				pend_cnt_q <= base;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
		if (fire && store_en) begin
			held_q[store_idx] <= byte_s1;
		end
		for (int j = 0; j < PEND_DEPTH; j++) begin
			pend_q[j] <= pend_nx[j];
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= 3'(PEND_DEPTH))
		else $error("result buffer count beyond its depth");

	a_string_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> held_cnt_q == 2'd0 && !seen_bad_q)
		else $error("sequence state not cleared at the end of a string");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |-> res_n != 3'd0)
		else $error("final byte of a string produced no result");

	a_held_is_lead: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> (need == LEN_2 || need == LEN_3 || need == LEN_4))
		else $error("held sequence does not start with a lead byte");

	a_held_short: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> {1'b0, held_cnt_q} < need)
		else $error("held sequence already complete");
`endif

endmodule

[dv/tb_utf8_stream_sanitizer.sv]
// Self-checking testbench for the UTF-8 stream sanitizer: directed and random text strings,
// random idling on both channels, and emoji output switched off and on between phases.
// Depends on u8s_pkg, the channel interfaces in u8s_if and the utf8_stream_sanitizer RTL.
`timescale 1ns / 100ps

module tb_utf8_stream_sanitizer;
	import u8s_pkg::*;

	typedef logic [7:0] text_q_t[$];

	// Predicts the sanitized words from each accepted input word and holds them until the
	// block delivers them. Its state mirrors the block: the pending sequence, its length,
	// whether the current string has had a replacement, and the emoji setting.
	class utf8_clean_predictor;
		bit          emoji_on;
		logic [7:0]  held_seq[3];
		int unsigned held_n;
		bit          string_bad;
		int unsigned step_words;
		int unsigned errors;
		int unsigned words_checked;
		int unsigned strings_done;
		out_word_t   expected_words[$];

		function new();
			emoji_on      = 1'b1;
			held_n        = 0;
			string_bad    = 1'b0;
			errors        = 0;
			words_checked = 0;
			strings_done  = 0;
		endfunction

		// Length of the sequence that a byte opens; LEN_BAD for a byte that cannot lead.
		function logic [2:0] lead_width(input logic [7:0] b);
			if (!b[7]) return LEN_1;
			if ((b & LEAD2_MASK) == LEAD2_CODE) return LEN_2;
			if ((b & LEAD3_MASK) == LEAD3_CODE) return LEN_3;
			if ((b & LEAD4_MASK) == LEAD4_CODE) return LEN_4;
			return LEN_BAD;
		endfunction

		function void put(input logic [7:0] b);
			out_word_t w;
			w.out_byte   = b;
			w.out_last   = 1'b0;
			w.text_clean = 1'b0;
			expected_words.push_back(w);
			step_words++;
		endfunction

		function void put_qmark();
			string_bad = 1'b1;
			put(QMARK);
		endfunction

		// A byte that does not continue a pending sequence is looked at on its own.
		function void start_fresh(input logic [7:0] b, input logic last);
			logic [2:0] len;
			len = lead_width(b);
			if (len == LEN_1) begin
				put(b);
			end else if (len == LEN_BAD || last) begin
				put_qmark();
			end else begin
				held_seq[0] = b;
				held_n      = 1;
			end
		endfunction

		function void take_byte(input logic [7:0] b, input logic last);
			logic [2:0] need;
			logic       cont;
			out_word_t  tail;
			step_words = 0;
			if (held_n != 0) begin
				need = lead_width(held_seq[0]);
				cont = (b & CONT_MASK) == CONT_CODE;
				if (cont && held_n + 1 == need) begin
					// The sequence is complete; a four-byte one collapses to a
					// single question mark while emoji output is off.
					if (need == LEN_4 && !emoji_on) begin
						put_qmark();
					end else begin
						for (int i = 0; i < held_n; i++) put(held_seq[i]);
						put(b);
					end
					held_n = 0;
				end else if (cont && !last && held_n + 1 < need) begin
					held_seq[held_n] = b;
					held_n++;
				end else begin
					// Broken or cut off: every held byte is replaced and the new byte
					// is judged afresh.
					for (int i = 0; i < held_n; i++) put_qmark();
					held_n = 0;
					start_fresh(b, last);
				end
			end else begin
				start_fresh(b, last);
			end
			if (last) begin
				if (step_words != 0) begin
					tail            = expected_words.pop_back();
					tail.out_last   = 1'b1;
					tail.text_clean = !string_bad;
					expected_words.push_back(tail);
				end
				held_n     = 0;
				string_bad = 1'b0;
				strings_done++;
			end
		endfunction

		function void check_word(input out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected output word: byte %02h last %0b clean %0b",
					$time, got.out_byte, got.out_last, got.text_clean);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h, actual %02h",
					$time, want.out_byte, got.out_byte);
				errors++;
			end
			if (got.out_last !== want.out_last) begin
				$display("%0t: out_last expected %0b, actual %0b",
					$time, want.out_last, got.out_last);
				errors++;
			end
			if (got.text_clean !== want.text_clean) begin
				$display("%0t: text_clean expected %0b, actual %0b",
					$time, want.text_clean, got.text_clean);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	// When set, neither side idles; the final phase of the run uses this.
	bit          quiet = 1'b0;
	int unsigned bytes_sent = 0;

	utf8_clean_predictor predictor = new();

	u8s_in_if  in_ch();
	u8s_out_if out_ch();

	utf8_stream_sanitizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	always #1 clk = ~clk;

	// Each task below is entered and left just after a rising edge, so every drive is a
	// nonblocking assignment that the block sees at the following edge.

	// Offers one word, sometimes after a burst of idle cycles, and hands it to the predictor
	// at the edge where it is taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do @(posedge clk); while (!in_ch.ready);
		predictor.take_byte(b, last);
		bytes_sent++;
	endtask

	// Sends a whole string; its final byte carries the last flag.
	task automatic send_text(input text_q_t text);
		for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
	endtask

	// Stops offering words, waits for every predicted word to arrive and then lets the
	// block settle, since a word that only opens a sequence gives nothing.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (predictor.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_emoji(input logic enable);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= enable;
		@(posedge clk);
		predictor.emoji_on = enable;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] random_lead(input int unsigned len);
		case (len)
			2: return 8'($urandom_range(8'hC0, 8'hDF));
			3: return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF7));
		endcase
	endfunction

	// Builds a string from a handful of pieces. Most pieces are plain ASCII or well-formed
	// sequences with random content; the rest are sequences cut short, stray continuation
	// bytes, bytes that can never lead, and wholly random bytes. A short sequence at the
	// end of the string is the cut-off case.
	task automatic send_random_text();
		text_q_t     text;
		int unsigned pieces;
		int unsigned kind;
		int unsigned len;
		int unsigned keep;
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				text.push_back(8'($urandom_range(0, 127)));
			end else if (kind < 75) begin
				len = $urandom_range(2, 4);
				text.push_back(random_lead(len));
				repeat (len - 1) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (kind < 85) begin
				len  = $urandom_range(2, 4);
				keep = $urandom_range(0, len - 2);
				text.push_back(random_lead(len));
				repeat (keep) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (kind < 95) begin
				if ($urandom_range(0, 1) == 0) begin
					text.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end else begin
					text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
				end
			end else begin
				text.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_text(text);
	endtask

	// Output side: every accepted word is checked against the oldest prediction, then
	// ready is driven for the next edge, with random stall bursts unless the run is quiet.
	initial begin : result_sink
		int unsigned stall_left;
		out_word_t   got;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.out_byte   = out_ch.out_byte;
				got.out_last   = out_ch.out_last;
				got.text_clean = out_ch.text_clean;
				predictor.check_word(got);
			end
			if (quiet) begin
				stall_left = 0;
				out_ch.ready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : text_source
		text_q_t text;
		in_ch.valid   <= 1'b0;
		in_ch.in_byte <= 8'h00;
		in_ch.in_last <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= 1'b0;
		arst_n        <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings with emoji output at its reset value of one.
		// The ASCII extremes, which form a clean string.
		text = {8'h00, 8'h7F};
		send_text(text);
		// A well-formed two-, three- and four-byte sequence in one string.
		text = {8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
		send_text(text);
		// A stray continuation byte and a byte that can never lead.
		text = {8'h80, 8'hFF};
		send_text(text);
		// A broken three-byte sequence, then the lowest of the never-lead bytes.
		text = {8'hE2, 8'h41, 8'hF8};
		send_text(text);
		// A lead byte that is itself the end of the string.
		text = {8'hC3};
		send_text(text);
		// A four-byte sequence broken after three bytes, then one cut off by the end.
		text = {8'hF0, 8'h9F, 8'h98, 8'h41, 8'hE2, 8'hBF};
		send_text(text);

		// With emoji output off a complete four-byte sequence becomes a single question
		// mark, while a broken one still gives one per held byte.
		write_emoji(1'b0);
		text = {8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF0, 8'h9F, 8'h41};
		send_text(text);

		// Random phases, switching the emoji setting between them.
		while (bytes_sent < 90) send_random_text();
		write_emoji(1'b1);
		while (bytes_sent < 150) send_random_text();
		write_emoji(1'b0);
		while (bytes_sent < 180) send_random_text();
		// The last stretch runs with both sides at full rate.
		quiet = 1'b1;
		write_emoji(1'b1);
		while (bytes_sent < 205) send_random_text();
		wait_idle();

		$display("Sent %0d input bytes in %0d strings and checked %0d output bytes,",
			bytes_sent, predictor.strings_done, predictor.words_checked);
		$display("with emoji output both on and off and with random stalls on both sides.");
		if (predictor.errors == 0 && predictor.outstanding() == 0) begin
			$display("utf8_stream_sanitizer verification clean");
		end else begin
			$display("utf8_stream_sanitizer verification failed");
		end
		$finish;
	end

	// Guard against a hang: far longer than the slowest correct run could take.
	initial begin : watchdog
		#200000;
		$display("utf8_stream_sanitizer verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/u8s_pkg.sv
rtl/core/u8s_if.sv
rtl/core/utf8_stream_sanitizer.sv
dv/tb_utf8_stream_sanitizer.sv
